>>> design/seguu_pkg.sv
// Package for the sensor exposure and gain update unit: widths, constants,
// register indexes, write slot codes and the controller/datapath structs.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package seguu_pkg;

	localparam int GAIN_W     = 16;
	localparam int LINE_W     = 16;
	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int ACTIVE_W   = 13;
	localparam int BLANK_W    = 8;
	localparam int FRAME_W    = 14;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int DIV_W      = 26;
	localparam int DIV_CNT_W  = 5;
	localparam int SLOT_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LINES = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_LINES  = 4'd1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_LINES_RST = 13'd980;
	localparam logic [BLANK_W-1:0]  BLANK_LINES_RST  = 8'd12;

	localparam logic [GAIN_W-1:0]  GAIN_LOW_TEST  = 16'h0030;
	localparam logic [LINE_W-1:0]  LINE_HALF_MIN  = 16'h0040;
	localparam logic [GAIN_W-1:0]  GAIN_HIGH_TEST = 16'h00a0;
	localparam logic [GAIN_W-1:0]  GAIN_CLAMP_LO  = 16'h0020;
	localparam logic [GAIN_W-1:0]  GAIN_CLAMP_HI  = 16'h0200;
	localparam logic [FRAME_W-1:0] FL_OFFSET      = 14'd12;
	localparam logic [DIV_W-1:0]   LL_PCK_BASE    = 26'd2738;
	localparam logic [DIV_W-1:0]   RATIO_ONE      = 26'h400;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 5'(DIV_W - 1);

	localparam logic [ADDR_W-1:0] ADDR_HOLD  = 16'h0104;
	localparam logic [ADDR_W-1:0] ADDR_GAIN  = 16'h0204;
	localparam logic [ADDR_W-1:0] ADDR_LLPCK = 16'h0342;
	localparam logic [ADDR_W-1:0] ADDR_LINE  = 16'h0202;

	localparam logic [SLOT_W-1:0] SLOT_HOLD_ON  = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_GAIN_HI  = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_GAIN_LO  = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_LLPCK_HI = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_LLPCK_LO = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_LINE_HI  = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_LINE_LO  = 3'd6;
	localparam logic [SLOT_W-1:0] SLOT_HOLD_OFF = 3'd7;

	typedef struct packed {
		logic              load_item;
		logic              div1_load;
		logic              div_step;
		logic              ratio_take;
		logic              line_take;
		logic              llpck_take;
		logic              commit;
		logic [SLOT_W-1:0] slot;
	} seguu_cmd_t;

	typedef struct packed {
		logic long_exp;
		logic changed;
	} seguu_status_t;

endpackage

`default_nettype wire

>>> design/seguu_if.sv
// Channel interfaces of the sensor exposure and gain update unit:
// gain request items, register write items and configuration writes.
// Depends on seguu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface seguu_req_if;
	logic                        valid;
	logic                        ready;
	logic [seguu_pkg::GAIN_W-1:0] requested_gain;

	modport source (output valid, output requested_gain, input ready);
	modport sink (input valid, input requested_gain, output ready);
endinterface

interface seguu_wr_if;
	logic                        valid;
	logic                        ready;
	logic [seguu_pkg::ADDR_W-1:0] reg_address;
	logic [seguu_pkg::BYTE_W-1:0] reg_value;
	logic                        last_write;

	modport source (output valid, output reg_address, output reg_value,
		output last_write, input ready);
	modport sink (input valid, input reg_address, input reg_value,
		input last_write, output ready);
endinterface

interface seguu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [seguu_pkg::CFG_IDX_W-1:0]  index;
	logic [seguu_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/seguu_datapath.sv
// Datapath of the sensor exposure and gain update unit: configuration and
// state registers, line and gain rules, shared serial divider, line length
// multiply and the write payload mux. Depends on seguu_pkg and seguu_if.
`timescale 1ns / 1ps
`default_nettype none

module seguu_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	seguu_cfg_if.sink                          cfg,
	input  wire logic [seguu_pkg::GAIN_W-1:0]   requested_gain,
	input  wire seguu_pkg::seguu_cmd_t          cmd,
	output seguu_pkg::seguu_status_t            status,
	output logic [seguu_pkg::ADDR_W-1:0]        reg_address,
	output logic [seguu_pkg::BYTE_W-1:0]        reg_value,
	output logic                                last_write
);
	import seguu_pkg::*;

	logic [ACTIVE_W-1:0] active_q;
	logic [BLANK_W-1:0]  blank_q;
	logic [LINE_W-1:0]   stored_line_q;
	logic [GAIN_W-1:0]   stored_gain_q;

	logic [GAIN_W-1:0]   gain_q;
	logic [LINE_W-1:0]   line_q;
	logic                long_q;
	logic [DIV_W-1:0]    ratio_q;
	logic [LINE_W-1:0]   llpck_q;

	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DIV_W-1:0]    dvs_q;

	logic [LINE_W-1:0]   active_ext;
	logic [LINE_W:0]     line_dbl;
	logic [LINE_W-1:0]   line_new;
	logic [GAIN_W-1:0]   gain_clamp;
	logic [FRAME_W-1:0]  frame_len;
	logic [FRAME_W-1:0]  frame_div;
	logic                long_new;
	logic [DIV_W:0]      div_shift;
	logic [DIV_W+1:0]    div_diff;
	logic                div_ge;
	logic [DIV_W-1:0]    ratio_fix;
	logic [DIV_W-1:0]    dividend;
	logic [DIV_W-1:0]    llpck_prod;
	logic                cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid & cfg.ready;

	assign active_ext = {{(LINE_W-ACTIVE_W){1'b0}}, active_q};
	assign line_dbl   = {stored_line_q, 1'b0};
	assign frame_len  = {1'b0, active_q} + {{(FRAME_W-BLANK_W){1'b0}}, blank_q};
	assign frame_div  = frame_len - FL_OFFSET;
	assign dividend   = {line_q, 10'b0};

	// The halving and doubling tests look at the gain before it is clamped.
	always_comb begin
		if ((requested_gain < GAIN_LOW_TEST) && (stored_line_q > LINE_HALF_MIN)) begin
			line_new = stored_line_q >> 1;
		end else if ((requested_gain > GAIN_HIGH_TEST) && (stored_line_q < active_ext)) begin
			line_new = (line_dbl > {1'b0, active_ext}) ? active_ext : line_dbl[LINE_W-1:0];
		end else begin
			line_new = stored_line_q;
		end
		if (requested_gain > GAIN_CLAMP_HI) begin
			gain_clamp = GAIN_CLAMP_HI;
		end else if (requested_gain < GAIN_CLAMP_LO) begin
			gain_clamp = GAIN_CLAMP_LO;
		end else begin
			gain_clamp = requested_gain;
		end
		long_new = (frame_len > FL_OFFSET) &&
			(line_new > {{(LINE_W-FRAME_W){1'b0}}, frame_len});
	end

	// One restoring division step per cycle; quo_q shifts the dividend out
	// and the quotient in.
	assign div_shift = {rem_q, quo_q[DIV_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_q};
	assign div_ge    = ~div_diff[DIV_W+1];
	assign ratio_fix = (quo_q == '0) ? RATIO_ONE : quo_q;

	assign llpck_prod = ratio_q * LL_PCK_BASE;

	assign status.long_exp = long_q;
	assign status.changed  = (line_q != stored_line_q) || (gain_q != stored_gain_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= ACTIVE_LINES_RST;
			blank_q       <= BLANK_LINES_RST;
			stored_line_q <= {{(LINE_W-ACTIVE_W){1'b0}}, ACTIVE_LINES_RST};
			stored_gain_q <= '0;
		end else begin
			if (cfg_we && (cfg.index == REG_ACTIVE_LINES)) begin
				active_q      <= cfg.data[ACTIVE_W-1:0];
				stored_line_q <= {{(LINE_W-ACTIVE_W){1'b0}}, cfg.data[ACTIVE_W-1:0]};
			end else if (cmd.commit) begin
				stored_line_q <= line_q;
				stored_gain_q <= gain_q;
			end
			if (cfg_we && (cfg.index == REG_BLANK_LINES)) begin
				blank_q <= cfg.data[BLANK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			gain_q  <= gain_clamp;
			line_q  <= line_new;
			long_q  <= long_new;
			ratio_q <= RATIO_ONE;
		end
		if (cmd.div1_load) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= {{(DIV_W-FRAME_W){1'b0}}, frame_div};
		end else if (cmd.ratio_take) begin
			ratio_q <= ratio_fix;
			rem_q   <= '0;
			quo_q   <= dividend;
			dvs_q   <= ratio_fix;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], div_ge};
		end
		if (cmd.line_take) begin
			line_q <= quo_q[LINE_W-1:0];
		end
		if (cmd.llpck_take) begin
			llpck_q <= llpck_prod[DIV_W-1:10];
		end
	end

	always_comb begin
		last_write = (cmd.slot == SLOT_HOLD_OFF);
		case (cmd.slot)
			SLOT_HOLD_ON: begin
				reg_address = ADDR_HOLD;
				reg_value   = 8'd1;
			end
			SLOT_GAIN_HI: begin
				reg_address = ADDR_GAIN;
				reg_value   = gain_q[15:8];
			end
			SLOT_GAIN_LO: begin
				reg_address = ADDR_GAIN + 16'd1;
				reg_value   = gain_q[7:0];
			end
			SLOT_LLPCK_HI: begin
				reg_address = ADDR_LLPCK;
				reg_value   = llpck_q[15:8];
			end
			SLOT_LLPCK_LO: begin
				reg_address = ADDR_LLPCK + 16'd1;
				reg_value   = llpck_q[7:0];
			end
			SLOT_LINE_HI: begin
				reg_address = ADDR_LINE;
				reg_value   = line_q[15:8];
			end
			SLOT_LINE_LO: begin
				reg_address = ADDR_LINE + 16'd1;
				reg_value   = line_q[7:0];
			end
			default: begin
				reg_address = ADDR_HOLD;
				reg_value   = 8'd0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/seguu_ctrl.sv
// Controller of the sensor exposure and gain update unit: sequences item
// load, the two serial divisions, the line length step and the eight writes.
// Depends on seguu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module seguu_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	input  wire seguu_pkg::seguu_status_t status,
	output seguu_pkg::seguu_cmd_t         cmd
);
	import seguu_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EVAL = 4'd1;
	localparam logic [3:0] ST_DIV1 = 4'd2;
	localparam logic [3:0] ST_RAT  = 4'd3;
	localparam logic [3:0] ST_DIV2 = 4'd4;
	localparam logic [3:0] ST_FIN  = 4'd5;
	localparam logic [3:0] ST_LLP  = 4'd6;
	localparam logic [3:0] ST_CHK  = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	logic [3:0]           state_q;
	logic [3:0]           state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 in_fire;
	logic                 out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_fire   = in_valid & in_ready;
	assign out_fire  = out_valid & out_ready;

	always_comb begin
		cmd            = '0;
		cmd.slot       = slot_q;
		cmd.load_item  = in_fire;
		cmd.div1_load  = (state_q == ST_EVAL) && status.long_exp;
		cmd.div_step   = (state_q == ST_DIV1) || (state_q == ST_DIV2);
		cmd.ratio_take = (state_q == ST_RAT);
		cmd.line_take  = (state_q == ST_FIN);
		cmd.llpck_take = (state_q == ST_LLP);
		cmd.commit     = (state_q == ST_CHK) && status.changed;

		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = status.long_exp ? ST_DIV1 : ST_LLP;
			end
			ST_DIV1: begin
				if (cnt_q == DIV_LAST) state_d = ST_RAT;
			end
			ST_RAT: begin
				state_d = ST_DIV2;
			end
			ST_DIV2: begin
				if (cnt_q == DIV_LAST) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_LLP;
			end
			ST_LLP: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = status.changed ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (out_fire && (slot_q == SLOT_HOLD_OFF)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			slot_q  <= SLOT_HOLD_ON;
		end else begin
			state_q <= state_d;
			if (cmd.div_step && (cnt_q != DIV_LAST)) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_CHK) begin
				slot_q <= SLOT_HOLD_ON;
			end else if (out_fire) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/sensor_exposure_gain_update_unit.sv
// Top level of the sensor exposure and gain update unit: joins the
// controller and the datapath to the request, write and configuration
// channels. Depends on seguu_pkg, seguu_if, seguu_ctrl and seguu_datapath.
//
// Each requested gain item derives a new exposure line count from the stored
// one and the unclamped gain, clamps the gain, then emits eight sensor byte
// writes (group hold on, gain, line length, exposure, group hold off), or
// nothing when neither line nor gain changed. One item is in work at a time;
// a new item is taken only once the last one and its writes are done. When
// the exposure runs past the frame length, a shared restoring divider runs
// twice at one quotient bit per cycle. Configuration writes are always
// taken; writing active_lines also reloads the stored line.
`timescale 1ns / 1ps
`default_nettype none

module sensor_exposure_gain_update_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	seguu_req_if.sink req,
	seguu_wr_if.source upd,
	seguu_cfg_if.sink cfg
);
	import seguu_pkg::*;

	seguu_cmd_t    cmd;
	seguu_status_t status;

	seguu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (upd.valid),
		.out_ready (upd.ready),
		.status    (status),
		.cmd       (cmd)
	);

	seguu_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.requested_gain (req.requested_gain),
		.cmd            (cmd),
		.status         (status),
		.reg_address    (upd.reg_address),
		.reg_value      (upd.reg_value),
		.last_write     (upd.last_write)
	);

endmodule

`default_nettype wire
